// File: rtl/tdpt_pkg.sv
package tdpt_pkg;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;        // capture a new candidate, divisor back to three
		logic div_start;   // launch one division of candidate by divisor
		logic next_div;    // step the divisor to the next odd value
		logic finish;      // register the result beat
		logic prime_flag;  // verdict that goes with finish
	} tdpt_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic trivial;        // decided without any division
		logic trivial_prime;  // verdict for the trivial case
		logic div_done;       // quotient and remainder are valid
		logic bound_over;     // divisor exceeds quotient, no more divisors to try
		logic rem_zero;       // divisor divides the candidate
	} tdpt_status_t;

	localparam logic [1:0] FIRST_DIVISOR = 2'd3;
	localparam logic [1:0] DIVISOR_STEP  = 2'd2;
	localparam logic [1:0] SMALLEST_PRIME = 2'd2;

endpackage

// File: rtl/trial_division_prime_test.sv
// Trial-division primality tester. Pulse start while busy is low to hand in one
// candidate; busy rises in the next cycle and stays high until the verdict is ready.
// The result beat (tested_value, prime) appears for exactly one cycle with done
// high and must be taken then, since the block cannot be stalled. Zero, one, two
// and other even values are decided in the classify state with no division. An odd
// value runs one restoring division per odd trial divisor, three, five and so on,
// until a divisor divides it or the divisor exceeds the quotient. The single
// iterative divider is reused for every trial divisor.
module trial_division_prime_test #(
	parameter int VALUE_WIDTH = 31
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [VALUE_WIDTH-1:0] candidate,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] tested_value,
	output logic                   prime
);

	tdpt_pkg::tdpt_cmd_t    cmd;
	tdpt_pkg::tdpt_status_t status;

	tdpt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.status(status),
		.cmd   (cmd)
	);

	tdpt_datapath #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.candidate   (candidate),
		.done        (done),
		.tested_value(tested_value),
		.prime       (prime)
	);

endmodule

// File: rtl/tdpt_divider.sv
module tdpt_divider #(
	parameter int VALUE_WIDTH = 31
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [VALUE_WIDTH-1:0] divisor,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] quotient,
	output logic [VALUE_WIDTH-1:0] remainder
);

	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [VALUE_WIDTH-1:0] dvs_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   run_q;
	logic                   done_q;
	logic [VALUE_WIDTH:0]   trial;
	logic                   fits;
	logic [VALUE_WIDTH:0]   diff;

	// restoring division, one quotient bit per cycle; quo_q shifts the dividend out
	assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(VALUE_WIDTH);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
			quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: rtl/tdpt_datapath.sv
module tdpt_datapath #(
	parameter int VALUE_WIDTH = 31
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tdpt_pkg::tdpt_cmd_t    cmd,
	output tdpt_pkg::tdpt_status_t status,
	input  logic [VALUE_WIDTH-1:0] candidate,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] tested_value,
	output logic                   prime
);

	logic [VALUE_WIDTH-1:0] n_q;
	logic [VALUE_WIDTH-1:0] d_q;
	logic [VALUE_WIDTH-1:0] res_value_q;
	logic                   res_prime_q;
	logic                   done_q;
	logic                   div_done;
	logic [VALUE_WIDTH-1:0] quotient;
	logic [VALUE_WIDTH-1:0] remainder;

	tdpt_divider #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (n_q),
		.divisor  (d_q),
		.done     (div_done),
		.quotient (quotient),
		.remainder(remainder)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= candidate;
			d_q <= VALUE_WIDTH'(tdpt_pkg::FIRST_DIVISOR);
		end else if (cmd.next_div) begin
			d_q <= d_q + VALUE_WIDTH'(tdpt_pkg::DIVISOR_STEP);
		end
		if (cmd.finish) begin
			res_value_q <= n_q;
			res_prime_q <= cmd.prime_flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	// zero, one, two and the other even values need no division
	always_comb begin
		status.trivial       = (n_q <= VALUE_WIDTH'(tdpt_pkg::SMALLEST_PRIME)) || !n_q[0];
		status.trivial_prime = n_q == VALUE_WIDTH'(tdpt_pkg::SMALLEST_PRIME);
		status.div_done      = div_done;
		// d > n / d is the same as d * d > n
		status.bound_over    = d_q > quotient;
		status.rem_zero      = remainder == '0;
	end

	assign done         = done_q;
	assign tested_value = res_value_q;
	assign prime        = res_prime_q;

endmodule

// File: rtl/tdpt_ctrl.sv
module tdpt_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  tdpt_pkg::tdpt_status_t status,
	output tdpt_pkg::tdpt_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE     = 4'b0001,
		S_CLASSIFY = 4'b0010,
		S_LAUNCH   = 4'b0100,
		S_DIV      = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CLASSIFY;
				end
			end
			S_CLASSIFY: begin
				if (status.trivial) begin
					cmd.finish     = 1'b1;
					cmd.prime_flag = status.trivial_prime;
					state_d        = S_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_LAUNCH: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (status.div_done) begin
					if (status.bound_over) begin
						cmd.finish     = 1'b1;
						cmd.prime_flag = 1'b1;
						state_d        = S_IDLE;
					end else if (status.rem_zero) begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end else begin
						cmd.next_div = 1'b1;
						state_d      = S_LAUNCH;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

// File: rtl/tdpt_checker.sv
module tdpt_checker #(
	parameter int VALUE_WIDTH = 31
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input logic [VALUE_WIDTH-1:0] tested_value,
	input logic                   prime
);

	// an accepted beat makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	// the result closes the work: busy has dropped when done shows
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("done without a preceding busy period");

	// result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// a prime verdict is never given for values below two or other even values
	a_prime_sane: assert property (@(posedge clk) disable iff (!arst_n)
		done && prime |-> (tested_value[0] && tested_value != VALUE_WIDTH'(1))
			|| tested_value == VALUE_WIDTH'(2))
		else $error("prime verdict on an even value or on one");

endmodule

bind trial_division_prime_test tdpt_checker #(
	.VALUE_WIDTH(VALUE_WIDTH)
) u_tdpt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.tested_value(tested_value),
	.prime       (prime)
);
